[src/frlc_pkg.sv]
// package for the fifo replacement lookup cache
// holds sizes, the controller state type and the cell control struct
// no dependencies
package frlc_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int WORD_BITS   = 10;
    localparam int CFG_W       = 8;
    localparam int COUNT_W     = 16;

    // capacity register holds 1..MAX_ENTRIES
    localparam int IDX_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;

    // match reduction: groups of GRP bits, then one final or
    localparam int GRP  = 16;
    localparam int NGRP = (MAX_ENTRIES + GRP - 1) / GRP;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED_GRP,
        ST_RED_ALL,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic cmp;    // compare and drop entries beyond capacity
        logic shift;  // take neighbour's entry
    } t_cell_ctl;

endpackage

[src/fifo_replacement_lookup_cache_top.sv]
// top level of the fifo replacement lookup cache
// chain of frlc_cell entries, frlc_match_tree reduction and the controller
// depends on frlc_pkg, frlc_cell, frlc_match_tree
//
//  channel   direction  transfer when                 payload
//  command   in         start && !busy                i_word_code
//  result    out        o_valid (one cycle, no stall) o_hit, o_miss_total
//  config    in         i_cfg_valid && o_cfg_ready    i_cfg_capacity
//
// an item runs from the command through these steps: compare in the cells,
// or over groups of 16 match bits, final or, chain update; busy is high during them
// the result strobe comes in the idle state after the chain update, while busy is low
// synchronous active-low reset clears all valid marks, the miss count and the
// controller, and sets capacity to the maximum; tags are not cleared
// results cannot be held off, so nothing ever stalls inside the block
module fifo_replacement_lookup_cache_top import frlc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_word_code,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [COUNT_W-1:0]   o_miss_total,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_capacity
);

    t_state r_state, n_state;

    logic [WORD_BITS-1:0] r_code;
    logic [IDX_W-1:0]     r_cap;
    logic [COUNT_W-1:0]   r_miss, n_miss;
    logic                 r_out_valid;
    logic                 r_out_hit;

    t_cell_ctl              w_ctl;
    logic                   w_grp_en;
    logic                   w_all_en;
    logic                   w_hit;
    logic [MAX_ENTRIES-1:0] w_match;
    logic [WORD_BITS-1:0]   w_tag   [MAX_ENTRIES];
    logic                   w_valid [MAX_ENTRIES];
    logic [CAP_W-1:0]       w_cfg_wide;
    logic [IDX_W-1:0]       w_cap_live;
    logic                   w_accept;

    assign w_accept    = start && !busy;
    assign o_cfg_ready = !busy;

    // clamp capacity to 1..MAX_ENTRIES on the way in
    assign w_cfg_wide = CAP_W'(i_cfg_capacity);
    always_comb begin
        priority if (i_cfg_capacity == '0) begin
            w_cap_live = IDX_W'(1);
        end else if (w_cfg_wide > CAP_W'(MAX_ENTRIES)) begin
            w_cap_live = IDX_W'(MAX_ENTRIES);
        end else begin
            w_cap_live = IDX_W'(w_cfg_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= IDX_W'(MAX_ENTRIES);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= w_cap_live;
        end
    end

    // controller
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (start) n_state = ST_CMP;
            ST_CMP:     n_state = ST_RED_GRP;
            ST_RED_GRP: n_state = ST_RED_ALL;
            ST_RED_ALL: n_state = ST_UPD;
            ST_UPD:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        w_ctl     = '0;
        w_grp_en  = 1'b0;
        w_all_en  = 1'b0;
        unique case (r_state)
            ST_IDLE:    busy = 1'b0;
            ST_CMP:     w_ctl.cmp = 1'b1;
            ST_RED_GRP: w_grp_en = 1'b1;
            ST_RED_ALL: w_all_en = 1'b1;
            ST_UPD:     w_ctl.shift = !w_hit;
            default:    busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code <= i_word_code;
        end
    end

    // saturating miss count
    always_comb begin
        n_miss = r_miss;
        if (r_state == ST_UPD && !w_hit && !(&r_miss)) begin
            n_miss = r_miss + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_miss      <= n_miss;
            r_out_valid <= (r_state == ST_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_out_hit <= w_hit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_miss_total = r_miss;

    // the chain: entry 0 is newest, a miss moves every in-use entry one place on
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [WORD_BITS-1:0] w_prev_tag;
        logic                 w_prev_valid;
        logic                 w_in_use;

        if (i == 0) begin : g_head
            assign w_prev_tag   = r_code;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_tag   = w_tag[i-1];
            assign w_prev_valid = w_valid[i-1];
        end

        assign w_in_use = IDX_W'(i) < r_cap;

        frlc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_in_use     (w_in_use),
            .i_code       (r_code),
            .i_prev_tag   (w_prev_tag),
            .i_prev_valid (w_prev_valid),
            .o_tag        (w_tag[i]),
            .o_valid      (w_valid[i]),
            .o_match      (w_match[i])
        );
    end

    frlc_match_tree u_tree (
        .i_clk    (i_clk),
        .i_grp_en (w_grp_en),
        .i_all_en (w_all_en),
        .i_match  (w_match),
        .o_hit    (w_hit)
    );

endmodule

[src/frlc_cell.sv]
// one entry of the tag chain: tag, valid mark and registered match
// depends on frlc_pkg
module frlc_cell import frlc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic                 i_in_use,
    input  logic [WORD_BITS-1:0] i_code,
    input  logic [WORD_BITS-1:0] i_prev_tag,
    input  logic                 i_prev_valid,
    output logic [WORD_BITS-1:0] o_tag,
    output logic                 o_valid,
    output logic                 o_match
);

    logic [WORD_BITS-1:0] r_tag;
    logic                 r_valid;
    logic                 r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_valid <= r_valid & i_in_use;
        end else if (i_ctl.shift && i_in_use) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && i_in_use) begin
            r_tag <= i_prev_tag;
        end
        if (i_ctl.cmp) begin
            r_match <= r_valid & i_in_use & (r_tag == i_code);
        end
    end

    assign o_tag   = r_tag;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

[src/frlc_match_tree.sv]
// two-level registered or tree over the cells' match bits
// depends on frlc_pkg
module frlc_match_tree import frlc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_grp_en,
    input  logic                   i_all_en,
    input  logic [MAX_ENTRIES-1:0] i_match,
    output logic                   o_hit
);

    logic [NGRP*GRP-1:0] w_match_pad;
    logic [NGRP-1:0]     r_grp;
    logic                r_hit;

    assign w_match_pad = {{(NGRP*GRP - MAX_ENTRIES){1'b0}}, i_match};

    always_ff @(posedge i_clk) begin
        if (i_grp_en) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp[g] <= |w_match_pad[g*GRP +: GRP];
            end
        end
        if (i_all_en) begin
            r_hit <= |r_grp;
        end
    end

    assign o_hit = r_hit;

endmodule

[src/frlc_checker.sv]
// port-level checker for the fifo replacement lookup cache, with its bind
// depends on frlc_pkg and fifo_replacement_lookup_cache_top
module frlc_checker import frlc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic               o_hit,
    input logic [COUNT_W-1:0] o_miss_total
);

    // every command is followed by a result strobe
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##5 o_valid)
        else $error("result strobe missing after command");

    // results never come back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a hit leaves the miss count untouched
    a_hit_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_miss_total == $past(o_miss_total))
        else $error("miss count moved on a hit");

    // the miss count never goes down
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_miss_total >= $past(o_miss_total))
        else $error("miss count decreased");

endmodule

bind fifo_replacement_lookup_cache_top frlc_checker u_frlc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_hit        (o_hit),
    .o_miss_total (o_miss_total)
);
